// ===== design/dcpd_pkg.sv =====
`timescale 1ns / 1ps

package dcpd_pkg;

   // Curve geometry.
   localparam int POSITION_COUNT = 4000;
   localparam int EDGE_LENGTH    = 100;

   // Fixed limits of the controller.
   localparam int ANGLE_FLOOR = 20;
   localparam int ANGLE_MAX   = POSITION_COUNT - 1;
   localparam int DRIVE_LIMIT = 255;
   localparam int ERROR_MAX   = 4095;
   localparam int ERROR_MIN   = -4096;

   // Field and datapath widths.
   localparam int ANGLE_IN_W = 16;
   localparam int ANGLE_W    = $clog2(POSITION_COUNT);
   localparam int DRIVE_W    = 9;
   localparam int LEVEL_W    = 8;
   localparam int GAIN_W     = 24;
   localparam int ERROR_W    = 13;
   localparam int EDER_W     = ERROR_W + 1;
   localparam int DIFF_W     = (ANGLE_W + 2 > ERROR_W + 1) ? ANGLE_W + 2 : ERROR_W + 1;
   localparam int P_TERM_W   = GAIN_W + ERROR_W;
   localparam int D_TERM_W   = GAIN_W + EDER_W;
   localparam int SUM_W      = D_TERM_W + 1;
   localparam int FRAC_W     = 16;
   localparam int MAG_W      = SUM_W - FRAC_W;

   // Ramp of curve two: floor(y * 255 / span) is computed as
   // (y * ceil(255 * 2^RAMP_SHIFT / span)) >> RAMP_SHIFT, which is exact
   // because y times the rounding excess stays far below 2^RAMP_SHIFT.
   localparam int     RAMP_SPAN_RAW = POSITION_COUNT - 2 * EDGE_LENGTH;
   localparam int     RAMP_SPAN     = (RAMP_SPAN_RAW > 0) ? RAMP_SPAN_RAW : 1;
   localparam int     RAMP_SHIFT    = 32;
   localparam longint RAMP_MUL      =
      ((64'(DRIVE_LIMIT) << RAMP_SHIFT) + 64'(RAMP_SPAN) - 64'd1) / 64'(RAMP_SPAN);
   localparam int     RAMP_MUL_W    = $clog2(RAMP_MUL + 1);
   localparam int     RAMP_PROD_W   = (ANGLE_W + RAMP_MUL_W > RAMP_SHIFT + LEVEL_W) ?
                                      ANGLE_W + RAMP_MUL_W : RAMP_SHIFT + LEVEL_W;

   // Register port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic signed [GAIN_W-1:0] KP_GAIN_RESET = 24'sd6554;
   localparam logic signed [GAIN_W-1:0] KD_GAIN_RESET = 24'sd0;

   typedef enum logic [0:0] {
      CSR_KP_GAIN = 1'b0,
      CSR_KD_GAIN = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [GAIN_W-1:0] kp;
      logic signed [GAIN_W-1:0] kd;
   } gain_type;

   // First stage result: clamped angle and curve selection.
   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic               low_band;
      logic               high_band;
      logic               rising;
      logic [LEVEL_W-1:0] ramp;
   } curve_stage_type;

   // Second stage result: the two gain products.
   typedef struct packed {
      logic signed [P_TERM_W-1:0] p_term;
      logic signed [D_TERM_W-1:0] d_term;
   } term_stage_type;

endpackage

// ===== design/dcpd_req_if.sv =====
`timescale 1ns / 1ps

interface dcpd_req_if import dcpd_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_IN_W-1:0] measured_angle;

   modport source (output valid, output measured_angle, input ready);
   modport sink (input valid, input measured_angle, output ready);
endinterface

// ===== design/dcpd_rsp_if.sv =====
`timescale 1ns / 1ps

interface dcpd_rsp_if import dcpd_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic [LEVEL_W-1:0]        forward_level;
   logic [LEVEL_W-1:0]        reverse_level;

   modport source (output valid, output drive, output forward_level, output reverse_level,
                   input ready);
   modport sink (input valid, input drive, input forward_level, input reverse_level,
                 output ready);
endinterface

// ===== design/dcpd_csr.sv =====
`timescale 1ns / 1ps

module dcpd_csr import dcpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output gain_type              gains
);

   gain_type      gains_ff;
   gain_type      gains_in;
   csr_index_type csr_index;
   logic          write_strobe;

   // Registers are word aligned; the low address bits are ignored.
   assign csr_index    = csr_index_type'(csr_paddr[2]);
   assign write_strobe = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready   = 1'b1;

   // Register write decode.
   always_comb begin
      gains_in = gains_ff;
      if (write_strobe) begin
         case (csr_index)
            CSR_KP_GAIN: gains_in.kp = csr_pwdata[GAIN_W-1:0];
            CSR_KD_GAIN: gains_in.kd = csr_pwdata[GAIN_W-1:0];
            default:     gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.kp <= KP_GAIN_RESET;
         gains_ff.kd <= KD_GAIN_RESET;
      end else begin
         gains_ff <= gains_in;
      end
   end

   // Read back, sign extended to the bus width.
   always_comb begin
      case (csr_index)
         CSR_KP_GAIN: csr_prdata = CSR_DATA_W'(gains_ff.kp);
         CSR_KD_GAIN: csr_prdata = CSR_DATA_W'(gains_ff.kd);
         default:     csr_prdata = '0;
      endcase
   end

   assign gains = gains_ff;

endmodule

// ===== design/dcpd_curve.sv =====
`timescale 1ns / 1ps

module dcpd_curve import dcpd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   dcpd_req_if.sink        req_if,
   output logic            stage_valid,
   output curve_stage_type stage_data
);

   logic [ANGLE_W-1:0]     angle;
   logic [ANGLE_W-1:0]     ramp_offset;
   logic [RAMP_PROD_W-1:0] ramp_product;
   logic                   accept;
   curve_stage_type        stage_in;
   curve_stage_type        stage_ff;
   logic                   valid_ff;
   logic                   valid_in;
   logic [ANGLE_W-1:0]     prev_angle_ff;
   logic [ANGLE_W-1:0]     prev_angle_in;

   assign req_if.ready = advance;
   assign accept       = req_if.valid && advance;

   // Clamp the reading so that it always lands inside the curve.
   always_comb begin
      if (req_if.measured_angle > ANGLE_MAX) begin
         angle = ANGLE_W'(ANGLE_MAX);
      end else if (req_if.measured_angle < ANGLE_FLOOR) begin
         angle = ANGLE_W'(ANGLE_FLOOR);
      end else begin
         angle = req_if.measured_angle[ANGLE_W-1:0];
      end
   end

   // Ramp value by reciprocal multiplication; only used in the middle band.
   assign ramp_offset  = angle - ANGLE_W'(EDGE_LENGTH);
   assign ramp_product = RAMP_PROD_W'(ramp_offset) * RAMP_PROD_W'(RAMP_MUL);

   always_comb begin
      stage_in.angle     = angle;
      stage_in.low_band  = (angle < EDGE_LENGTH);
      stage_in.high_band = (angle >= POSITION_COUNT - EDGE_LENGTH);
      stage_in.rising    = (angle > prev_angle_ff);
      stage_in.ramp      = ramp_product[RAMP_SHIFT +: LEVEL_W];
   end

   assign valid_in      = advance ? req_if.valid : valid_ff;
   assign prev_angle_in = accept ? angle : prev_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         prev_angle_ff <= '0;
      end else begin
         valid_ff      <= valid_in;
         prev_angle_ff <= prev_angle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = stage_ff;

endmodule

// ===== design/dcpd_error.sv =====
`timescale 1ns / 1ps

module dcpd_error import dcpd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  gain_type        gains,
   input  logic            curve_valid,
   input  curve_stage_type curve_data,
   output logic            stage_valid,
   output term_stage_type  stage_data
);

   logic signed [DRIVE_W-1:0] target;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [ERROR_W-1:0] error;
   logic signed [EDER_W-1:0]  eder;
   logic signed [ERROR_W-1:0] prev_error_ff;
   logic signed [ERROR_W-1:0] prev_error_in;
   term_stage_type            stage_in;
   term_stage_type            stage_ff;
   logic                      valid_ff;
   logic                      valid_in;

   // Target from the curve; the upper band wins where the bands overlap.
   always_comb begin
      if (curve_data.high_band) begin
         target = DRIVE_W'(DRIVE_LIMIT);
      end else if (curve_data.low_band) begin
         target = -DRIVE_W'(DRIVE_LIMIT);
      end else if (curve_data.rising) begin
         target = '0;
      end else begin
         target = $signed(DRIVE_W'(curve_data.ramp));
      end
   end

   // Error with saturation to its stored width.
   assign diff = DIFF_W'(target) - $signed(DIFF_W'(curve_data.angle));

   always_comb begin
      if (diff > ERROR_MAX) begin
         error = ERROR_W'(ERROR_MAX);
      end else if (diff < ERROR_MIN) begin
         error = ERROR_W'(ERROR_MIN);
      end else begin
         error = diff[ERROR_W-1:0];
      end
   end

   assign eder = EDER_W'(error) - EDER_W'(prev_error_ff);

   // Proportional and derivative products.
   assign stage_in.p_term = P_TERM_W'(gains.kp) * P_TERM_W'(error);
   assign stage_in.d_term = D_TERM_W'(gains.kd) * D_TERM_W'(eder);

   assign valid_in      = advance ? curve_valid : valid_ff;
   assign prev_error_in = (advance && curve_valid) ? error : prev_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         prev_error_ff <= '0;
      end else begin
         valid_ff      <= valid_in;
         prev_error_ff <= prev_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = stage_ff;

endmodule

// ===== design/dcpd_drive.sv =====
`timescale 1ns / 1ps

module dcpd_drive import dcpd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           term_valid,
   input  term_stage_type term_data,
   output logic           advance,
   dcpd_rsp_if.source     rsp_if
);

   logic signed [SUM_W-1:0]   sum;
   logic [SUM_W-1:0]          sum_abs;
   logic [MAG_W-1:0]          mag;
   logic                      negative;
   logic [LEVEL_W-1:0]        level;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [DRIVE_W-1:0] drive_ff;
   logic signed [DRIVE_W-1:0] drive_in;
   logic [LEVEL_W-1:0]        forward_ff;
   logic [LEVEL_W-1:0]        forward_in;
   logic [LEVEL_W-1:0]        reverse_ff;
   logic [LEVEL_W-1:0]        reverse_in;

   // The whole pipeline moves whenever the result register can take a value.
   assign advance = !rsp_valid_ff || rsp_if.ready;

   // Sum, truncate the magnitude toward zero and saturate.
   assign sum      = SUM_W'(term_data.p_term) + SUM_W'(term_data.d_term);
   assign negative = sum[SUM_W-1];
   assign sum_abs  = negative ? SUM_W'(-sum) : SUM_W'(sum);
   assign mag      = sum_abs[SUM_W-1:FRAC_W];
   assign level    = (|mag[MAG_W-1:LEVEL_W]) ? LEVEL_W'(DRIVE_LIMIT) : mag[LEVEL_W-1:0];

   // Split into signed drive and the two direction magnitudes.
   always_comb begin
      if (negative) begin
         drive_in   = -$signed(DRIVE_W'(level));
         forward_in = '0;
         reverse_in = level;
      end else begin
         drive_in   = $signed(DRIVE_W'(level));
         forward_in = level;
         reverse_in = '0;
      end
   end

   assign rsp_valid_in = advance ? term_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         drive_ff   <= drive_in;
         forward_ff <= forward_in;
         reverse_ff <= reverse_in;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.drive         = drive_ff;
   assign rsp_if.forward_level = forward_ff;
   assign rsp_if.reverse_level = reverse_ff;

endmodule

// ===== design/direction_curve_pd_controller.sv =====
`timescale 1ns / 1ps

// Direction-dependent PD position controller. Each request carries one encoder
// angle, which is clamped to the curve, compared with the previous angle to pick
// the rising curve (flat middle) or the falling curve (linear ramp), and turned
// into a drive command by a PD law with signed gains in units of 1/65536; the
// result is truncated toward zero, saturated to +/-255 and also given as forward
// and reverse magnitudes. The block takes one request per clock while its output is not
// stalled, and the result passes through one stage each for the curve lookup
// multiply, the two gain multiplies and the sum and saturation. The stages move
// together, so while a finished result waits at the output the block holds off
// new requests. The user must write gains over the register port only while no
// request is in flight; the block itself does not enforce this.
module direction_curve_pd_controller import dcpd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   dcpd_req_if.sink              req_if,
   dcpd_rsp_if.source            rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   gain_type        gains;
   logic            advance;
   logic            curve_valid;
   curve_stage_type curve_data;
   logic            term_valid;
   term_stage_type  term_data;

   dcpd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gains       (gains)
   );

   dcpd_curve u_curve (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .req_if      (req_if),
      .stage_valid (curve_valid),
      .stage_data  (curve_data)
   );

   dcpd_error u_error (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .gains       (gains),
      .curve_valid (curve_valid),
      .curve_data  (curve_data),
      .stage_valid (term_valid),
      .stage_data  (term_data)
   );

   dcpd_drive u_drive (
      .clock      (clock),
      .reset      (reset),
      .term_valid (term_valid),
      .term_data  (term_data),
      .advance    (advance),
      .rsp_if     (rsp_if)
   );

`ifndef SYNTH
   // Only one direction magnitude is ever nonzero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.forward_level == '0 || rsp_if.reverse_level == '0))
      else $error("forward and reverse levels both nonzero");

   // The drive stays inside its saturation limits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.drive <= DRIVE_LIMIT && rsp_if.drive >= -DRIVE_LIMIT))
      else $error("drive outside saturation range");

   // A stalled pipeline keeps its occupancy.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(curve_valid) && $stable(term_valid)))
      else $error("pipeline occupancy changed during a stall");

   // An accepted request reaches the output when the pipeline does not stall.
   assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) ##1 advance ##1 advance |=> rsp_if.valid)
      else $error("accepted request did not produce a result");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import dcpd_pkg::*;

   localparam int PHASE_COUNT     = 9;
   localparam int PHASE_ITEMS     = 175;
   localparam int DIRECTED_COUNT  = 21;
   localparam int PIPE_LATENCY    = 3;
   localparam int STALL_LIMIT     = 5000;
   localparam int PAUSE_POINT     = 60;

   typedef struct {
      logic signed [DRIVE_W-1:0] drive;
      logic [LEVEL_W-1:0]        forward_level;
      logic [LEVEL_W-1:0]        reverse_level;
   } drive_command_type;

   typedef struct packed {
      logic signed [ANGLE_IN_W-1:0] angle;
      logic                         pinned;
      logic signed [DRIVE_W-1:0]    drive;
   } angle_row_type;

   // Directed requests, issued right after reset with the reset gains. The first
   // request from the cleared state and the five rows after it, which saturate, carry their drive.
   localparam angle_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{16'sh8000, 1'b1, -9'sd27},   // clamped up to the floor, rising from zero
      '{16'sh7FFF, 1'b1, -9'sd255},  // clamped down to the last position
      '{16'sd3999, 1'b1, -9'sd255},  // equal angle takes curve two
      '{16'sd4000, 1'b1, -9'sd255},  // one past the table, clamped
      '{16'sd3900, 1'b1, -9'sd255},  // first position of the upper band
      '{16'sd3899, 1'b1, -9'sd255},  // top of the ramp
      '{16'sd3899, 1'b0, 9'sd0},
      '{16'sd3901, 1'b0, 9'sd0},
      '{16'sd2000, 1'b0, 9'sd0},
      '{16'sd1999, 1'b0, 9'sd0},
      '{16'sd100,  1'b0, 9'sd0},
      '{16'sd99,   1'b0, 9'sd0},
      '{16'sd101,  1'b0, 9'sd0},
      '{16'sd19,   1'b0, 9'sd0},
      '{16'sd20,   1'b0, 9'sd0},
      '{16'sd21,   1'b0, 9'sd0},
      '{16'sd0,    1'b0, 9'sd0},
      '{16'shFFFF, 1'b0, 9'sd0},
      '{16'sh5555, 1'b0, 9'sd0},
      '{16'shAAAA, 1'b0, 9'sd0},
      '{16'sd1,    1'b0, 9'sd0}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   dcpd_req_if req_ch ();
   dcpd_rsp_if rsp_ch ();

   direction_curve_pd_controller dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Controller state as the predictor sees it.
   int kp_now       = KP_GAIN_RESET;
   int kd_now       = KD_GAIN_RESET;
   int last_angle   = 0;
   int stored_error = 0;

   drive_command_type drive_q[$];

   int  req_idle_pct = 0;
   int  rsp_idle_pct = 0;
   bit  pin_active   = 1'b0;
   int  pin_drive    = 0;
   logic signed [ANGLE_IN_W-1:0] last_sent = '0;

   int errors       = 0;
   int sent_count   = 0;
   int result_count = 0;
   int positive_count, negative_count, zero_count, limit_count;
   int stall_cycles = 0;

   // Splits a signed drive into the command and its two magnitudes.
   function automatic drive_command_type split_drive(input int value);
      drive_command_type r;
      r.drive         = DRIVE_W'(value);
      r.forward_level = (value >= 0) ? LEVEL_W'(value) : '0;
      r.reverse_level = (value < 0) ? LEVEL_W'(-value) : '0;
      return r;
   endfunction

   // Works out the drive for one angle and advances the stored angle and error.
   function automatic drive_command_type compute_drive(
      input logic signed [ANGLE_IN_W-1:0] raw
   );
      int     angle;
      int     target;
      int     err;
      int     err_delta;
      int     value;
      bit     rising;
      longint sum;
      longint mag;
      angle = raw;
      if (angle > ANGLE_MAX) angle = ANGLE_MAX;
      if (angle < ANGLE_FLOOR) angle = ANGLE_FLOOR;
      rising = angle > last_angle;
      if (angle >= POSITION_COUNT - EDGE_LENGTH) begin
         target = DRIVE_LIMIT;
      end else if (angle < EDGE_LENGTH) begin
         target = -DRIVE_LIMIT;
      end else if (rising) begin
         target = 0;
      end else begin
         target = (angle - EDGE_LENGTH) * DRIVE_LIMIT / (POSITION_COUNT - 2 * EDGE_LENGTH);
      end
      err = target - angle;
      if (err > ERROR_MAX) err = ERROR_MAX;
      if (err < ERROR_MIN) err = ERROR_MIN;
      err_delta = err - stored_error;
      sum = longint'(kp_now) * err + longint'(kd_now) * err_delta;
      // Truncate toward zero by shifting the magnitude, then saturate.
      mag = ((sum < 0) ? -sum : sum) >>> FRAC_W;
      if (mag > DRIVE_LIMIT) mag = DRIVE_LIMIT;
      value = (sum < 0) ? -int'(mag) : int'(mag);
      last_angle   = angle;
      stored_error = err;
      return split_drive(value);
   endfunction

   // Random angle: mostly inside the table, with band edges, repeats and small
   // steps around the previous request so both curves get exercised.
   function automatic logic signed [ANGLE_IN_W-1:0] pick_angle();
      int edges [12] = '{19, 20, 21, 99, 100, 101, 3899, 3900, 3901, 3998, 3999, 4000};
      case ($urandom_range(9))
         0: return ANGLE_IN_W'($urandom);
         1: return ANGLE_IN_W'(edges[$urandom_range(11)]);
         2: return last_sent;
         3, 4: return last_sent + ANGLE_IN_W'(int'($urandom_range(40)) - 20);
         default: return ANGLE_IN_W'($urandom_range(4100));
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side stalls at the rate currently chosen.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Requests are predicted on acceptance, results checked on acceptance.
   always @(posedge clock) begin
      drive_command_type want;
      drive_command_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            want = compute_drive(req_ch.measured_angle);
            if (pin_active) want = split_drive(pin_drive);
            drive_q.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.drive         = rsp_ch.drive;
            got.forward_level = rsp_ch.forward_level;
            got.reverse_level = rsp_ch.reverse_level;
            result_count++;
            if (got.drive > 0) positive_count++;
            else if (got.drive < 0) negative_count++;
            else zero_count++;
            if (got.drive == DRIVE_LIMIT || got.drive == -DRIVE_LIMIT) limit_count++;
            if (drive_q.size() == 0) begin
               $display("%0t: unexpected result, drive %0d", $time, got.drive);
               errors++;
            end else begin
               want = drive_q.pop_front();
               if (got.drive !== want.drive) begin
                  $display("%0t: drive expected %0d actual %0d",
                           $time, want.drive, got.drive);
                  errors++;
               end
               if (got.forward_level !== want.forward_level) begin
                  $display("%0t: forward_level expected %0d actual %0d",
                           $time, want.forward_level, got.forward_level);
                  errors++;
               end
               if (got.reverse_level !== want.reverse_level) begin
                  $display("%0t: reverse_level expected %0d actual %0d",
                           $time, want.reverse_level, got.reverse_level);
                  errors++;
               end
            end
         end
      end
      // Watchdog on cycles where nothing moves on any port.
      if (reset || csr_psel || (req_ch.valid && req_ch.ready) ||
          (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // Issues one request after a random gap and holds it until accepted.
   task automatic send_angle(input logic signed [ANGLE_IN_W-1:0] angle,
                             input bit pinned, input int pinned_drive);
      while ($urandom_range(99) < req_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      pin_active = pinned;
      pin_drive  = pinned_drive;
      req_ch.valid          <= 1'b1;
      req_ch.measured_angle <= angle;
      do @(posedge clock); while (!req_ch.ready);
      last_sent = angle;
      sent_count++;
   endtask

   // Holds off requests until every expected result has come back.
   task automatic drain_results();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (drive_q.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 1) @(posedge clock);
   endtask

   // Writes one gain register, then reads it back.
   task automatic write_gain(input csr_index_type index,
                             input logic signed [GAIN_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({index, 2'b00});
      csr_pwdata  <= {{(CSR_DATA_W - GAIN_W){value[GAIN_W-1]}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == CSR_KP_GAIN) kp_now = value;
      else kd_now = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[GAIN_W-1:0] !== value) begin
         $display("%0t: gain %s readback expected %0d actual %0d", $time, index.name(),
                  value, $signed(csr_prdata[GAIN_W-1:0]));
         errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Stimulus: directed table, then phases of random angles under new gains.
   initial begin
      logic signed [GAIN_W-1:0] kp_set;
      logic signed [GAIN_W-1:0] kd_set;
      req_ch.valid          = 1'b0;
      req_ch.measured_angle = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      reset       = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_idle_pct = 26;
      rsp_idle_pct = 63;
      foreach (DIRECTED_ROWS[i]) begin
         send_angle(DIRECTED_ROWS[i].angle, DIRECTED_ROWS[i].pinned,
                    DIRECTED_ROWS[i].drive);
      end
      drain_results();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         // Gains: sign flips, both extremes, unity, zero, derivative only, then random ones.
         case (phase)
            0: begin kp_set = -24'sd6554;   kd_set = 24'sd0;        end
            1: begin kp_set = 24'sh7FFFFF;  kd_set = 24'sh800000;   end
            2: begin kp_set = 24'sh800000;  kd_set = 24'sh7FFFFF;   end
            3: begin kp_set = 24'sd65536;   kd_set = 24'sd65536;    end
            4: begin kp_set = 24'sd0;       kd_set = 24'sd0;        end
            5: begin kp_set = 24'sd0;       kd_set = -24'sd300000;  end
            6: begin kp_set = GAIN_W'($urandom); kd_set = GAIN_W'($urandom); end
            default: begin
               kp_set = GAIN_W'(int'($urandom_range(200000)) - 100000);
               kd_set = GAIN_W'(int'($urandom_range(200000)) - 100000);
            end
         endcase
         write_gain(CSR_KP_GAIN, kp_set);
         write_gain(CSR_KD_GAIN, kd_set);

         case (phase / 3)
            0: begin req_idle_pct = 26; rsp_idle_pct = 63; end
            1: begin req_idle_pct = 63; rsp_idle_pct = 26; end
            default: begin req_idle_pct = 0; rsp_idle_pct = 0; end
         endcase

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PAUSE_POINT) drain_results();
            send_angle(pick_angle(), 1'b0, 0);
         end
         drain_results();
      end

      repeat (PIPE_LATENCY * 4) @(posedge clock);
      if (drive_q.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, drive_q.size());
         errors++;
      end

      $display("Ran %0d angle requests under %0d gain settings with three idling patterns.",
               sent_count, PHASE_COUNT + 1);
      $display("Checked %0d results: %0d forward, %0d reverse, %0d zero, %0d saturated.",
               result_count, positive_count, negative_count, zero_count, limit_count);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/dcpd_pkg.sv
design/dcpd_req_if.sv
design/dcpd_rsp_if.sv
design/dcpd_csr.sv
design/dcpd_curve.sv
design/dcpd_error.sv
design/dcpd_drive.sv
design/direction_curve_pd_controller.sv
verif/tb.sv
